[src/rectangle_canvas_painter_assert.svh]
// Assertion macros for the rectangle canvas painter checker.
// Included by the checker file; expects clk and rst in scope.
`ifndef RECTANGLE_CANVAS_PAINTER_ASSERT_SVH
`define RECTANGLE_CANVAS_PAINTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rcp_pkg.sv]
// Shared types and codes for the rectangle canvas painter.
// No dependencies; used by the top level, the pixel classifier and the checker.
`timescale 1ns / 1ps

package rcp_pkg;

  // Signed coordinate width: covers col << FRAC_BITS over the whole parameter range
  // and sums of 19-bit Q corners and spans.
  localparam int COORD_W = 28;
  localparam int QW      = 19;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_BAD_RECT   = 2'd1;
  localparam logic [1:0] STAT_OFF_CANVAS = 2'd2;

  localparam logic [7:0] KIND_FILLED  = 8'h52;  // 'R'
  localparam logic [7:0] KIND_OUTLINE = 8'h72;  // 'r'

  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BACKGROUND    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RADDR,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PC_OUT,
    PC_EDGE,
    PC_INNER
  } pix_class_t;

  // Bounds along one axis: inside when lo <= p <= hi,
  // near an edge when p < near_lo or p > near_hi.
  typedef struct packed {
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
    logic signed [COORD_W-1:0] near_lo;
    logic signed [COORD_W-1:0] near_hi;
  } axis_bounds_t;

  function automatic logic signed [COORD_W-1:0] sext_q(logic [QW-1:0] v);
    return {{(COORD_W-QW){v[QW-1]}}, v};
  endfunction

endpackage

[src/rcp_pixel_class.sv]
// Pixel classifier: compares one pixel point against the registered rectangle bounds.
// Depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_pixel_class (
  input  logic signed [rcp_pkg::COORD_W-1:0] px,
  input  logic signed [rcp_pkg::COORD_W-1:0] py,
  input  rcp_pkg::axis_bounds_t              bx,
  input  rcp_pkg::axis_bounds_t              by,
  output rcp_pkg::pix_class_t                cls
);
  import rcp_pkg::*;

  logic in_rect;
  logic near;

  always_comb begin
    in_rect = ($signed(px) >= $signed(bx.lo)) && ($signed(px) <= $signed(bx.hi)) &&
              ($signed(py) >= $signed(by.lo)) && ($signed(py) <= $signed(by.hi));
    near    = ($signed(px) < $signed(bx.near_lo)) || ($signed(px) > $signed(bx.near_hi)) ||
              ($signed(py) < $signed(by.near_lo)) || ($signed(py) > $signed(by.near_hi));
    if (!in_rect) begin
      cls = PC_OUT;
    end else if (near) begin
      cls = PC_EDGE;
    end else begin
      cls = PC_INNER;
    end
  end

endmodule

[src/rectangle_canvas_painter.sv]
// Rectangle canvas painter top level: command sequencer, canvas memory, output register.
// Depends on rcp_pkg and rcp_pixel_class.
`timescale 1ns / 1ps
//
//  channel   dir  signals                       beat contents
//  s_*       in   s_tvalid/s_tready/s_tdata/u   one command (clear, draw, read)
//  m_*       out  m_tvalid/m_tready/m_tdata     status and pixel byte, one per command
//  cfg_*     in   cfg_we/cfg_addr/cfg_wdata     register write, no wait
//
//  Clear and valid draw: walk all w*h pixels (one pixel per cycle through the classifier
//  and the single memory write port), then the result load.
//  Read: address multiply, registered memory read, result load.
//  Invalid draw, off-canvas read, unused func: straight to the result load.
//  s_tready is high only while idle; a finished beat waits in the output register.
//  Reset is synchronous; the canvas memory is not cleared by reset.

module rectangle_canvas_painter #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [7:0] shape_kind, [26:8] corner_x, [45:27] corner_y, [64:46] span_x,
  // [83:65] span_y, [91:84] paint_byte, [99:92] pixel_col, [107:100] pixel_row
  input  logic [111:0] s_tdata,
  // [1:0] func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] status, [9:2] pixel_value
  output logic [15:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [8:0]   cfg_wdata
);
  import rcp_pkg::*;

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

  // configuration
  logic [8:0] canvas_width;
  logic [8:0] canvas_height;
  logic [7:0] background_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= 9'd256;
      canvas_height   <= 9'd256;
      background_byte <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CANVAS_WIDTH:  canvas_width    <= cfg_wdata;
        REG_CANVAS_HEIGHT: canvas_height   <= cfg_wdata;
        REG_BACKGROUND:    background_byte <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // effective sizes, clamped to 1..MAX_SIDE
  logic [10:0] w_raw, h_raw, eff_w11, eff_h11;
  logic [SW-1:0] eff_w, eff_h;

  always_comb begin
    w_raw = {2'b00, canvas_width};
    h_raw = {2'b00, canvas_height};
    if (w_raw == 11'd0) eff_w11 = 11'd1;
    else if (w_raw > 11'(MAX_SIDE)) eff_w11 = 11'(MAX_SIDE);
    else eff_w11 = w_raw;
    if (h_raw == 11'd0) eff_h11 = 11'd1;
    else if (h_raw > 11'(MAX_SIDE)) eff_h11 = 11'(MAX_SIDE);
    else eff_h11 = h_raw;
    eff_w = SW'(eff_w11);
    eff_h = SW'(eff_h11);
  end

  // input fields
  logic [1:0]    in_func;
  logic [7:0]    in_kind;
  logic [QW-1:0] in_cx, in_cy, in_sx, in_sy;
  logic [7:0]    in_paint, in_col, in_row;

  assign in_func  = s_tuser;
  assign in_kind  = s_tdata[7:0];
  assign in_cx    = s_tdata[26:8];
  assign in_cy    = s_tdata[45:27];
  assign in_sx    = s_tdata[64:46];
  assign in_sy    = s_tdata[83:65];
  assign in_paint = s_tdata[91:84];
  assign in_col   = s_tdata[99:92];
  assign in_row   = s_tdata[107:100];

  logic rect_ok, read_off;
  logic signed [COORD_W-1:0] cx_s, cy_s, ex_s, ey_s;
  logic [21:0] rd_prod;

  always_comb begin
    rect_ok  = ((in_kind == KIND_FILLED) || (in_kind == KIND_OUTLINE)) &&
               !in_sx[QW-1] && (|in_sx) && !in_sy[QW-1] && (|in_sy);
    read_off = ({3'b000, in_col} >= eff_w11) || ({3'b000, in_row} >= eff_h11);
    cx_s     = sext_q(in_cx);
    cy_s     = sext_q(in_cy);
    ex_s     = cx_s + sext_q(in_sx);
    ey_s     = cy_s + sext_q(in_sy);
    rd_prod  = 22'(in_row) * 22'(eff_w11) + 22'(in_col);
  end

  // sequencer
  state_t state, state_next;
  logic   accept, wr_en, out_load, walk_last, paint_hit;

  logic              op_clear, filled, res_read;
  logic [1:0]        res_status;
  logic [7:0]        wr_byte;
  axis_bounds_t      bx, by;
  logic [AW-1:0]     addr;
  logic [SW-1:0]     walk_col, walk_row;
  logic [7:0]        rd_data;
  pix_class_t        cls;
  logic signed [COORD_W-1:0] px, py;

  assign accept    = s_tvalid && s_tready;
  assign walk_last = (walk_col == eff_w - SW'(1)) && (walk_row == eff_h - SW'(1));
  assign px        = COORD_W'(walk_col) << FRAC_BITS;
  assign py        = COORD_W'(walk_row) << FRAC_BITS;
  assign paint_hit = (cls == PC_EDGE) || ((cls == PC_INNER) && filled);

  rcp_pixel_class u_class (
    .px  (px),
    .py  (py),
    .bx  (bx),
    .by  (by),
    .cls (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_func)
            FUNC_CLEAR: state_next = ST_WALK;
            FUNC_DRAW:  state_next = rect_ok ? ST_WALK : ST_DONE;
            FUNC_READ:  state_next = read_off ? ST_DONE : ST_RADDR;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        wr_en = op_clear || paint_hit;
        if (walk_last) state_next = ST_DONE;
      end
      ST_RADDR: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // command capture and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_col <= '0;
      walk_row <= '0;
    end else if (state == ST_WALK) begin
      if (walk_col == eff_w - SW'(1)) begin
        walk_col <= '0;
        walk_row <= walk_last ? '0 : walk_row + SW'(1);
      end else begin
        walk_col <= walk_col + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_clear   <= (in_func == FUNC_CLEAR);
      filled     <= (in_kind == KIND_FILLED);
      res_read   <= (in_func == FUNC_READ) && !read_off;
      wr_byte    <= (in_func == FUNC_CLEAR) ? background_byte : in_paint;
      bx         <= '{lo: cx_s, hi: ex_s, near_lo: cx_s + ONE, near_hi: ex_s - ONE};
      by         <= '{lo: cy_s, hi: ey_s, near_lo: cy_s + ONE, near_hi: ey_s - ONE};
      if (in_func == FUNC_DRAW && !rect_ok) res_status <= STAT_BAD_RECT;
      else if (in_func == FUNC_READ && read_off) res_status <= STAT_OFF_CANVAS;
      else res_status <= STAT_OK;
      addr       <= (in_func == FUNC_READ) ? AW'(rd_prod) : '0;
    end else if (state == ST_WALK) begin
      // row-major walk: the address just counts up
      addr <= addr + AW'(1);
    end
  end

  // canvas memory: one write port, one registered read port
  logic [7:0] canvas_store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) canvas_store[addr] <= wr_byte;
  end

  always_ff @(posedge clk) begin
    rd_data <= canvas_store[addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, (res_read ? rd_data : 8'd0), res_status};
    end
  end

endmodule

[src/rcp_checker.sv]
// Port-level checker for the rectangle canvas painter, bound to the top level.
// Depends on rcp_pkg and rectangle_canvas_painter_assert.svh.
`timescale 1ns / 1ps
`include "rectangle_canvas_painter_assert.svh"

module rcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import rcp_pkg::*;

  // stalled result beat must hold
  `RCP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

  // every accepted command drops ready in the cycle after the accept
  `RCP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

  // a result appears only out of a busy cycle
  `RCP_ASSERT_NOW(a_result_from_busy, $rose(m_tvalid), $past(!s_tready), "result without busy cycle")

  // failed commands return a zero pixel byte
  `RCP_ASSERT_NOW(a_zero_pixel_on_error, m_tvalid && (m_tdata[1:0] != STAT_OK), m_tdata[9:2] == 8'd0, "nonzero pixel with error status")

endmodule

bind rectangle_canvas_painter rcp_checker u_rcp_checker (.*);

[verif/tb.sv]
// Testbench for the rectangle canvas painter: directed and random command streams,
// with the expected reply of every command worked out against a byte-array canvas copy.
// Depends on rcp_pkg and rectangle_canvas_painter.
`timescale 1ns / 1ps

module tb;
  import rcp_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int FRAC_BITS    = 8;
  localparam int Q_ONE        = 1 << FRAC_BITS;
  localparam int SIDE_MAX     = 256;
  localparam int RANDOM_ITEMS = 70;
  localparam int LONG_HOLD    = 6000;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct {
    logic [1:0]         func;
    logic [7:0]         kind;
    logic signed [18:0] corner_x;
    logic signed [18:0] corner_y;
    logic signed [18:0] span_x;
    logic signed [18:0] span_y;
    logic [7:0]         paint;
    logic [7:0]         pixel_col;
    logic [7:0]         pixel_row;
  } canvas_cmd_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] pixel;
  } canvas_reply_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [8:0]   cfg_wdata = '0;

  // canvas copy and register shadows
  logic [7:0]    canvas_model [SIDE_MAX*SIDE_MAX];
  logic [8:0]    width_reg = 9'd256;
  logic [8:0]    height_reg = 9'd256;
  logic [7:0]    background_reg = 8'd32;
  canvas_reply_t pending_replies[$];

  int fail_count = 0;
  int burst_left = 0;
  bit pace_sender = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;

  rectangle_canvas_painter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int clamp_side(logic [8:0] v);
    if (v == 0) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  // Updates the canvas copy and returns the reply beat the command should produce.
  function automatic canvas_reply_t apply_command(canvas_cmd_t c);
    canvas_reply_t r;
    int w, h, sx, sy, ex, ey, px, py;
    bit filled;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    r.status = STAT_OK;
    r.pixel = 8'd0;
    case (c.func)
      FUNC_CLEAR: begin
        for (int row = 0; row < h; row++)
          for (int col = 0; col < w; col++)
            canvas_model[col + row * w] = background_reg;
      end
      FUNC_DRAW: begin
        if ((c.kind != KIND_FILLED && c.kind != KIND_OUTLINE) ||
            int'(c.span_x) <= 0 || int'(c.span_y) <= 0) begin
          r.status = STAT_BAD_RECT;
        end else begin
          filled = (c.kind == KIND_FILLED);
          sx = c.corner_x;
          sy = c.corner_y;
          ex = sx + int'(c.span_x);
          ey = sy + int'(c.span_y);
          for (int row = 0; row < h; row++) begin
            for (int col = 0; col < w; col++) begin
              px = col * Q_ONE;
              py = row * Q_ONE;
              // closed rectangle; edge band is strictly less than one pixel wide
              if (px >= sx && px <= ex && py >= sy && py <= ey) begin
                if (filled || px - sx < Q_ONE || ex - px < Q_ONE ||
                    py - sy < Q_ONE || ey - py < Q_ONE)
                  canvas_model[col + row * w] = c.paint;
              end
            end
          end
        end
      end
      FUNC_READ: begin
        if (c.pixel_col >= w || c.pixel_row >= h) r.status = STAT_OFF_CANVAS;
        else r.pixel = canvas_model[c.pixel_col + c.pixel_row * w];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic canvas_cmd_t random_fields();
    canvas_cmd_t c;
    c.func      = 2'($urandom_range(0, 3));
    c.kind      = 8'($urandom);
    c.corner_x  = 19'($urandom);
    c.corner_y  = 19'($urandom);
    c.span_x    = 19'($urandom);
    c.span_y    = 19'($urandom);
    c.paint     = 8'($urandom);
    c.pixel_col = 8'($urandom);
    c.pixel_row = 8'($urandom);
    return c;
  endfunction

  function automatic canvas_cmd_t plain_cmd(logic [1:0] f);
    canvas_cmd_t c;
    c = random_fields();
    c.func = f;
    return c;
  endfunction

  function automatic canvas_cmd_t draw_cmd(logic [7:0] kind, int cx, int cy, int wx, int wy,
                                           logic [7:0] paint);
    canvas_cmd_t c;
    c = random_fields();
    c.func     = FUNC_DRAW;
    c.kind     = kind;
    c.corner_x = 19'(cx);
    c.corner_y = 19'(cy);
    c.span_x   = 19'(wx);
    c.span_y   = 19'(wy);
    c.paint    = paint;
    return c;
  endfunction

  function automatic canvas_cmd_t read_cmd(logic [7:0] col, logic [7:0] row);
    canvas_cmd_t c;
    c = random_fields();
    c.func      = FUNC_READ;
    c.pixel_col = col;
    c.pixel_row = row;
    return c;
  endfunction

  // Q11.8 value between lo and hi pixels; half the time on a whole pixel
  function automatic int random_q8(int lo, int hi);
    int q;
    q = int'($urandom_range(0, (hi - lo) * Q_ONE)) + lo * Q_ONE;
    if ($urandom_range(0, 1)) q = q & ~(Q_ONE - 1);
    return q;
  endfunction

  function automatic logic [8:0] random_side();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 9'd0;
    if (roll < 16) return 9'($urandom_range(1, 16));
    return 9'($urandom_range(17, 48));
  endfunction

  function automatic canvas_cmd_t random_command(int w, int h);
    canvas_cmd_t c;
    int roll, span;
    c = random_fields();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      c.func = FUNC_CLEAR;
    end else if (roll < 13) begin
      c.func = FUNC_UNUSED;
    end else if (roll < 48) begin
      c.func = FUNC_READ;
      if (roll < 43) begin
        c.pixel_col = 8'($urandom_range(0, w - 1));
        c.pixel_row = 8'($urandom_range(0, h - 1));
      end
    end else begin
      c.func = FUNC_DRAW;
      if (roll >= 56) begin
        c.kind     = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
        c.corner_x = 19'(random_q8(-3, w + 2));
        c.corner_y = 19'(random_q8(-3, h + 2));
        span = random_q8(0, w + 3);
        c.span_x = 19'((span > 0) ? span : Q_ONE);
        span = random_q8(0, h + 3);
        c.span_y = 19'((span > 0) ? span : Q_ONE);
      end else if (roll < 52) begin
        // raw coordinates with a legal kind
        c.kind = KIND_OUTLINE;
      end
    end
    return c;
  endfunction

  task automatic send_cmd(input canvas_cmd_t c);
    int gap;
    if (pace_sender && burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= c.func;
    s_tdata  <= {4'b0, c.pixel_row, c.pixel_col, c.paint, c.span_y, c.span_x,
                 c.corner_y, c.corner_x, c.kind};
    do @(posedge clk); while (!s_tready);
    pending_replies.push_back(apply_command(c));
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] wdata);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CANVAS_WIDTH:  width_reg = wdata;
      REG_CANVAS_HEIGHT: height_reg = wdata;
      REG_BACKGROUND:    background_reg = wdata[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // full 256x256 canvas: one clear and two large draws
  task automatic test_full_canvas();
    write_reg(REG_CANVAS_WIDTH, 9'd256);
    write_reg(REG_CANVAS_HEIGHT, 9'd256);
    send_cmd(plain_cmd(FUNC_CLEAR));
    send_cmd(read_cmd(8'd0, 8'd0));
    send_cmd(draw_cmd(KIND_FILLED, 10 * Q_ONE + 128, 3 * Q_ONE, 200 * Q_ONE,
                      240 * Q_ONE + 64, 8'hA5));
    // right edge lands on 256.0, bottom edge exactly on row 255
    send_cmd(draw_cmd(KIND_OUTLINE, 100 * Q_ONE + 64, 120 * Q_ONE, 155 * Q_ONE + 192,
                      135 * Q_ONE, 8'h5A));
    send_cmd(read_cmd(8'd11, 8'd3));
    send_cmd(read_cmd(8'd100, 8'd150));
    send_cmd(read_cmd(8'd101, 8'd150));
    send_cmd(read_cmd(8'd255, 8'd255));
  endtask

  task automatic test_draw_special_cases();
    wait_results_drained();
    write_reg(REG_CANVAS_WIDTH, 9'd12);
    write_reg(REG_CANVAS_HEIGHT, 9'd10);
    write_reg(REG_BACKGROUND, 9'hFF);
    send_cmd(plain_cmd(FUNC_CLEAR));
    // rejected: bad kind, zero width, negative height
    send_cmd(draw_cmd(8'h00, Q_ONE, Q_ONE, 4 * Q_ONE, 4 * Q_ONE, 8'h01));
    send_cmd(draw_cmd(8'hFF, Q_ONE, Q_ONE, 4 * Q_ONE, 4 * Q_ONE, 8'h02));
    send_cmd(draw_cmd(KIND_FILLED, Q_ONE, Q_ONE, 0, 4 * Q_ONE, 8'h03));
    send_cmd(draw_cmd(KIND_OUTLINE, Q_ONE, Q_ONE, 4 * Q_ONE, -262144, 8'h04));
    // legal but entirely off the canvas
    send_cmd(draw_cmd(KIND_OUTLINE, -262144, -262144, 262143, 262143, 8'h05));
    send_cmd(draw_cmd(KIND_FILLED, 262143, 0, 262143, 262143, 8'h06));
    // whole-pixel outline: pixels exactly 1.0 inside are not edge pixels
    send_cmd(draw_cmd(KIND_OUTLINE, 2 * Q_ONE, Q_ONE, 6 * Q_ONE, 5 * Q_ONE, 8'h11));
    // half-pixel rectangle that covers a single pixel center
    send_cmd(draw_cmd(KIND_FILLED, 9 * Q_ONE, 7 * Q_ONE - 64, 128, 128, 8'h00));
    send_cmd(plain_cmd(FUNC_UNUSED));
    send_cmd(read_cmd(8'd2, 8'd1));
    send_cmd(read_cmd(8'd3, 8'd3));
    send_cmd(read_cmd(8'd8, 8'd6));
    send_cmd(read_cmd(8'd9, 8'd7));
    send_cmd(read_cmd(8'd12, 8'd0));
    send_cmd(read_cmd(8'd0, 8'd10));
  endtask

  task automatic test_size_clamping();
    wait_results_drained();
    write_reg(REG_CANVAS_WIDTH, 9'd0);
    write_reg(REG_CANVAS_HEIGHT, 9'h1FF);
    write_reg(REG_BACKGROUND, 9'd0);
    write_reg(REG_UNUSED, 9'h1FF);
    send_cmd(plain_cmd(FUNC_CLEAR));
    send_cmd(read_cmd(8'd0, 8'd255));
    send_cmd(read_cmd(8'd1, 8'd0));
    wait_results_drained();
    write_reg(REG_CANVAS_WIDTH, 9'h1FF);
    write_reg(REG_CANVAS_HEIGHT, 9'd0);
    write_reg(REG_BACKGROUND, 9'h0FF);
    send_cmd(plain_cmd(FUNC_CLEAR));
    send_cmd(read_cmd(8'd255, 8'd0));
    send_cmd(read_cmd(8'd0, 8'd1));
  endtask

  // phases of random traffic, each on its own canvas size and opening with a clear
  task automatic test_random_traffic();
    int sent, phase, phase_len, w, h;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_results_drained();
      write_reg(REG_CANVAS_WIDTH, random_side());
      write_reg(REG_CANVAS_HEIGHT, random_side());
      write_reg(REG_BACKGROUND, 9'($urandom_range(0, 255)));
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      phase_len = $urandom_range(8, 16);
      // one phase runs back to back into a long receiver hold-off
      pace_sender = (phase != 2);
      if (phase == 2) hold_requests <= hold_requests + 1;
      send_cmd(plain_cmd(FUNC_CLEAR));
      for (int i = 1; i < phase_len; i++) send_cmd(random_command(w, h));
      sent += phase_len;
      phase++;
    end
    pace_sender = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_full_canvas();
    test_draw_special_cases();
    test_size_clamping();
    test_random_traffic();
    wait_results_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // receiver: changing ready pattern, plus long hold-offs on request
  initial begin : reply_sink
    int mode, mode_left, hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          2:       m_tready <= 1'($urandom_range(0, 1));
          3:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    canvas_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $error("reply beat with nothing pending: status %0d pixel_value 0x%02h",
               m_tdata[1:0], m_tdata[9:2]);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[9:2] !== want.pixel) begin
          $error("pixel_value: expected 0x%02h, actual 0x%02h", want.pixel, m_tdata[9:2]);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
